// ===== design/olist_pkg.sv =====
// Shared codes, defaults and controller/datapath interface types for the ordered list engine.
`default_nettype none

package olist_pkg;

    // Default sizing
    localparam int DEF_DEPTH = 16;
    localparam int DEF_WIDTH = 32;

    // Command codes
    localparam logic [2:0] CMD_APPEND = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_POP    = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_FIND   = 3'd4;
    localparam logic [2:0] CMD_DUMP   = 3'd5;

    // Status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;
    localparam logic [1:0] STS_EMPTY = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;    // latch the request
        logic decide;  // check the request, set up the walk
        logic read;    // issue one walk read
        logic finish;  // commit and report
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic walk;       // request needs a walk over the entries
        logic walk_last;  // the read being issued is the final one
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== design/ordered_list_engine.sv =====
// Top level of the ordered list engine: controller and datapath.
`default_nettype none

// A bounded ordered list of up to DEPTH words with append, insert, pop, delete,
// find and dump. A request is taken when i_start is high and o_busy is low;
// o_busy then stays high until the request has finished. Results come out
// one per cycle with o_valid high for a single cycle each and must be taken
// as they appear, since there is no back-pressure. A dump gives one result per
// stored entry with o_last on the final one, or one if empty; others give one.
// Timing is set by the single entry RAM port pair, walked one entry a cycle:
// append, pop and any rejected request go from decide straight to finish;
// insert, delete, find and dump walk the entries, if there are any, and
// drain before the finish: the entries from the position up for an insert,
// those above it for a delete, and the whole count for find and dump. Apart
// from a dump, the result appears in the first cycle with o_busy low; the
// final entry of a dump appears in the last cycle with o_busy high.

module ordered_list_engine #(
    parameter int DEPTH = olist_pkg::DEF_DEPTH,
    parameter int WIDTH = olist_pkg::DEF_WIDTH,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    output logic                  o_busy,
    input  wire logic [2:0]       i_command,
    input  wire logic [CW-1:0]    i_position,
    input  wire logic [WIDTH-1:0] i_value,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic                  o_found,
    output logic [CW-1:0]         o_count,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_last
);

    import olist_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    olist_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_busy  (o_busy),
        .o_cmd   (w_cmd),
        .i_stat  (w_stat)
    );

    olist_dp #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .CW    (CW)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_command  (i_command),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_found    (o_found),
        .o_count    (o_count),
        .o_data     (o_data),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

// ===== design/olist_ram.sv =====
// Generic simple dual-port RAM with registered read data.
`default_nettype none

module olist_ram #(
    parameter int WIDTH = olist_pkg::DEF_WIDTH,
    parameter int DEPTH = olist_pkg::DEF_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/olist_ctrl.sv =====
// Sequencing state machine for the ordered list engine.
`default_nettype none

module olist_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_start,
    output logic                     o_busy,
    output olist_pkg::t_dp_cmd       o_cmd,
    input  wire olist_pkg::t_dp_stat i_stat
);

    import olist_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_busy;

    // State and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_DECIDE;
                        r_busy  <= 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_state <= i_stat.walk ? S_WALK : S_FINISH;
                end
                S_WALK: begin
                    if (i_stat.walk_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    // Datapath commands decoded from state
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.decide = (r_state == S_DECIDE);
        o_cmd.read   = (r_state == S_WALK);
        o_cmd.finish = (r_state == S_FINISH);
    end

    assign o_busy = r_busy;

endmodule

`default_nettype wire

// ===== design/olist_dp.sv =====
// Datapath: request registers, entry count, entry RAM, walk pointer and result registers.
`default_nettype none

module olist_dp #(
    parameter int DEPTH = olist_pkg::DEF_DEPTH,
    parameter int WIDTH = olist_pkg::DEF_WIDTH,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire olist_pkg::t_dp_cmd  i_cmd,
    output olist_pkg::t_dp_stat      o_stat,
    input  wire logic [2:0]          i_command,
    input  wire logic [CW-1:0]       i_position,
    input  wire logic [WIDTH-1:0]    i_value,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic                     o_found,
    output logic [CW-1:0]            o_count,
    output logic [WIDTH-1:0]         o_data,
    output logic                     o_last
);

    import olist_pkg::*;

    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE        = CW'(1);

    // Request and list state
    logic [2:0]       r_cmd;
    logic [CW-1:0]    r_pos;
    logic [WIDTH-1:0] r_val;
    logic [CW-1:0]    r_count, n_count;
    logic [1:0]       r_status;
    logic             r_found;

    // Walk state
    logic [AW-1:0]    r_addr;
    logic             r_up;
    logic [CW-1:0]    r_remaining;
    logic             r_rd_valid;
    logic [AW-1:0]    r_rd_addr;

    // Result registers
    logic             r_o_valid, n_o_valid;
    logic [1:0]       r_o_status, n_o_status;
    logic             r_o_found, n_o_found;
    logic [CW-1:0]    r_o_count, n_o_count;
    logic [WIDTH-1:0] r_o_data, n_o_data;
    logic             r_o_last, n_o_last;

    // RAM ports
    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [WIDTH-1:0] w_wdata;
    logic [WIDTH-1:0] w_rdata;

    // Decision on the latched request
    logic [CW-1:0]    w_cnt_m1;
    logic [CW-1:0]    w_pos_p1;
    logic [1:0]       d_status;
    logic             d_walk;
    logic [AW-1:0]    d_start;
    logic             d_up;
    logic [CW-1:0]    d_len;

    assign w_cnt_m1 = r_count - ONE;
    assign w_pos_p1 = r_pos + ONE;

    always_comb begin
        d_status = STS_OK;
        d_walk   = 1'b0;
        d_start  = '0;
        d_up     = 1'b1;
        d_len    = r_count;
        case (r_cmd)
            CMD_APPEND: begin
                if (r_count >= FULL_COUNT) begin
                    d_status = STS_FULL;
                end
            end
            CMD_INSERT: begin
                if (r_count >= FULL_COUNT) begin
                    d_status = STS_FULL;
                end else if (r_pos > r_count) begin
                    d_status = STS_RANGE;
                end else begin
                    // shift up: read from the top entry down to the position
                    d_walk  = (r_pos < r_count);
                    d_start = w_cnt_m1[AW-1:0];
                    d_up    = 1'b0;
                    d_len   = r_count - r_pos;
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    d_status = STS_EMPTY;
                end
            end
            CMD_DELETE: begin
                if (r_count == '0) begin
                    d_status = STS_EMPTY;
                end else if (r_pos >= r_count) begin
                    d_status = STS_RANGE;
                end else begin
                    // shift down: read from just above the position to the top
                    d_walk  = (w_pos_p1 < r_count);
                    d_start = w_pos_p1[AW-1:0];
                    d_len   = w_cnt_m1 - r_pos;
                end
            end
            CMD_FIND: begin
                d_walk = (r_count != '0);
            end
            CMD_DUMP: begin
                if (r_count == '0) begin
                    d_status = STS_EMPTY;
                end else begin
                    d_walk = 1'b1;
                end
            end
            default: begin
                d_status = STS_OK;
            end
        endcase
    end

    assign o_stat.walk      = d_walk;
    assign o_stat.walk_last = (r_remaining == ONE);

    // Count after the request commits
    always_comb begin
        n_count = r_count;
        if (i_cmd.finish && (r_status == STS_OK)) begin
            case (r_cmd)
                CMD_APPEND, CMD_INSERT: n_count = r_count + ONE;
                CMD_POP, CMD_DELETE:    n_count = w_cnt_m1;
                default:                n_count = r_count;
            endcase
        end
    end

    // RAM write: shifted entries during the walk, the new word at the end
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_rd_addr;
        w_wdata = w_rdata;
        if (r_rd_valid && (r_cmd == CMD_INSERT)) begin
            w_we    = 1'b1;
            w_waddr = r_rd_addr + AW'(1);
        end else if (r_rd_valid && (r_cmd == CMD_DELETE)) begin
            w_we    = 1'b1;
            w_waddr = r_rd_addr - AW'(1);
        end else if (i_cmd.finish && (r_status == STS_OK) && (r_cmd == CMD_APPEND)) begin
            w_we    = 1'b1;
            w_waddr = r_count[AW-1:0];
            w_wdata = r_val;
        end else if (i_cmd.finish && (r_status == STS_OK) && (r_cmd == CMD_INSERT)) begin
            w_we    = 1'b1;
            w_waddr = r_pos[AW-1:0];
            w_wdata = r_val;
        end
    end

    olist_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    // Result selection: one per dumped entry, otherwise one at the finish
    always_comb begin
        n_o_valid  = 1'b0;
        n_o_status = r_o_status;
        n_o_found  = r_o_found;
        n_o_count  = r_o_count;
        n_o_data   = r_o_data;
        n_o_last   = r_o_last;
        if (r_rd_valid && (r_cmd == CMD_DUMP)) begin
            n_o_valid  = 1'b1;
            n_o_status = STS_OK;
            n_o_found  = 1'b0;
            n_o_count  = r_count;
            n_o_data   = w_rdata;
            n_o_last   = (r_rd_addr == w_cnt_m1[AW-1:0]);
        end else if (i_cmd.finish && !((r_cmd == CMD_DUMP) && (r_status == STS_OK))) begin
            n_o_valid  = 1'b1;
            n_o_status = r_status;
            n_o_found  = r_found;
            n_o_count  = n_count;
            n_o_data   = '0;
            n_o_last   = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_rd_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_rd_valid <= i_cmd.read;
            r_o_valid  <= n_o_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_pos <= i_position;
            r_val <= i_value;
        end
        if (i_cmd.decide) begin
            r_status    <= d_status;
            r_found     <= 1'b0;
            r_addr      <= d_start;
            r_up        <= d_up;
            r_remaining <= d_len;
        end else begin
            if (i_cmd.read) begin
                r_addr      <= r_up ? (r_addr + AW'(1)) : (r_addr - AW'(1));
                r_remaining <= r_remaining - ONE;
            end
            if (r_rd_valid && (r_cmd == CMD_FIND) && (w_rdata == r_val)) begin
                r_found <= 1'b1;
            end
        end
        r_rd_addr  <= r_addr;
        r_o_status <= n_o_status;
        r_o_found  <= n_o_found;
        r_o_count  <= n_o_count;
        r_o_data   <= n_o_data;
        r_o_last   <= n_o_last;
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_found  = r_o_found;
    assign o_count  = r_o_count;
    assign o_data   = r_o_data;
    assign o_last   = r_o_last;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the ordered list engine: queued request driver, strobe monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import olist_pkg::*;

    localparam int DEPTH = DEF_DEPTH;
    localparam int WIDTH = DEF_WIDTH;
    localparam int CW    = $clog2(DEPTH + 1);

    // Command codes the engine does not define; they must leave the list alone
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    localparam int N_RANDOM   = 440;
    localparam int TAIL_WAIT  = DEPTH + 8;

    // Stimulus generator modes
    typedef enum int {
        MODE_FILL,
        MODE_EMPTY_OUT,
        MODE_MIXED,
        MODE_NOISE
    } t_gen_mode;

    typedef struct {
        logic [2:0]       cmd;
        logic [CW-1:0]    pos;
        logic [WIDTH-1:0] val;
        bit               drain;   // hold off until every result has arrived
    } t_list_req;

    typedef struct {
        logic [1:0]       status;
        logic             found;
        logic [CW-1:0]    count;
        logic [WIDTH-1:0] data;
        logic             last;
    } t_list_result;

    logic             i_clk      = 1'b0;
    logic             i_rst_n    = 1'b0;
    logic             i_start    = 1'b0;
    logic [2:0]       i_command  = '0;
    logic [CW-1:0]    i_position = '0;
    logic [WIDTH-1:0] i_value    = '0;
    logic             o_busy;
    logic             o_valid;
    logic [1:0]       o_status;
    logic             o_found;
    logic [CW-1:0]    o_count;
    logic [WIDTH-1:0] o_data;
    logic             o_last;

    ordered_list_engine #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_command  (i_command),
        .i_position (i_position),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_found    (o_found),
        .o_count    (o_count),
        .o_data     (o_data),
        .o_last     (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Pending requests and the results they are predicted to give
    t_list_req    list_reqs_q[$];
    t_list_result list_results_q[$];

    // Shadow list kept in step with the engine
    logic [WIDTH-1:0] shadow_words [DEPTH];
    int               shadow_len;

    // Generator side: count tracking and a pool of stored words for find hits
    int               gen_len;
    logic [WIDTH-1:0] word_pool[$];

    int fail_count;
    int burst_left;
    int gap_left;

    // Work out the results of one accepted request and update the shadow list
    task automatic predict_list_op(input t_list_req rq);
        t_list_result r;
        int           i;
        r.status = STS_OK;
        r.found  = 1'b0;
        r.data   = '0;
        r.last   = 1'b1;
        case (rq.cmd)
            CMD_APPEND: begin
                if (shadow_len >= DEPTH) begin
                    r.status = STS_FULL;
                end else begin
                    shadow_words[shadow_len] = rq.val;
                    shadow_len++;
                end
            end
            CMD_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    r.status = STS_FULL;
                end else if (int'(rq.pos) > shadow_len) begin
                    r.status = STS_RANGE;
                end else begin
                    for (i = shadow_len; i > int'(rq.pos); i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[rq.pos] = rq.val;
                    shadow_len++;
                end
            end
            CMD_POP: begin
                if (shadow_len == 0)
                    r.status = STS_EMPTY;
                else
                    shadow_len--;
            end
            CMD_DELETE: begin
                if (shadow_len == 0) begin
                    r.status = STS_EMPTY;
                end else if (int'(rq.pos) >= shadow_len) begin
                    r.status = STS_RANGE;
                end else begin
                    for (i = int'(rq.pos); i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            CMD_FIND: begin
                for (i = 0; i < shadow_len; i++)
                    if (shadow_words[i] == rq.val)
                        r.found = 1'b1;
            end
            CMD_DUMP: begin
                if (shadow_len == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    // One result per stored entry, last flag on the final one
                    for (i = 0; i < shadow_len; i++) begin
                        r.count = shadow_len[CW-1:0];
                        r.data  = shadow_words[i];
                        r.last  = (i + 1 == shadow_len);
                        list_results_q.insert(list_results_q.size(), r);
                    end
                    return;
                end
            end
            default: ;
        endcase
        r.count = shadow_len[CW-1:0];
        list_results_q.insert(list_results_q.size(), r);
    endtask

    // Queue a request and track the list length the engine will have after it
    task automatic queue_list_req(input logic [2:0] cmd, input int pos,
                                  input logic [WIDTH-1:0] val, input bit drain);
        t_list_req rq;
        rq.cmd   = cmd;
        rq.pos   = pos[CW-1:0];
        rq.val   = val;
        rq.drain = drain;
        list_reqs_q.insert(list_reqs_q.size(), rq);
        case (cmd)
            CMD_APPEND: begin
                if (gen_len < DEPTH) begin
                    gen_len++;
                    word_pool.insert(word_pool.size(), val);
                end
            end
            CMD_INSERT: begin
                if (gen_len < DEPTH && pos <= gen_len) begin
                    gen_len++;
                    word_pool.insert(word_pool.size(), val);
                end
            end
            CMD_POP:    if (gen_len > 0) gen_len--;
            CMD_DELETE: if (gen_len > 0 && pos < gen_len) gen_len--;
            default: ;
        endcase
        if (word_pool.size() > 24)
            void'(word_pool.pop_front());
    endtask

    function automatic logic [WIDTH-1:0] pick_word();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        else if (sel == 1)
            return '1;
        else if (sel < 5)
            return WIDTH'($urandom_range(0, 7));   // small values repeat often
        else
            return WIDTH'($urandom);
    endfunction

    // Random part: segments that fill, empty out, mix or throw noise
    task automatic build_random_reqs();
        t_gen_mode        mode;
        int               seg_left;
        int               n;
        int               w;
        int               pos;
        logic [2:0]       cmd;
        logic [WIDTH-1:0] val;
        bit               drain;
        seg_left = 0;
        mode     = MODE_FILL;
        for (n = 0; n < N_RANDOM; n++) begin
            if (seg_left == 0) begin
                w        = $urandom_range(0, 9);
                mode     = (w < 3) ? MODE_FILL : (w < 6) ? MODE_EMPTY_OUT :
                           (w < 9) ? MODE_MIXED : MODE_NOISE;
                seg_left = $urandom_range(6, 30);
            end
            seg_left--;
            w = $urandom_range(0, 99);
            case (mode)
                MODE_FILL:
                    cmd = (w < 45) ? CMD_APPEND : (w < 80) ? CMD_INSERT :
                          (w < 90) ? CMD_FIND : (w < 96) ? CMD_DUMP : CMD_DELETE;
                MODE_EMPTY_OUT:
                    cmd = (w < 35) ? CMD_POP : (w < 75) ? CMD_DELETE :
                          (w < 85) ? CMD_FIND : (w < 93) ? CMD_DUMP : CMD_APPEND;
                MODE_MIXED:
                    cmd = 3'($urandom_range(0, 5));
                default:
                    cmd = 3'($urandom_range(0, 7));
            endcase
            // Mostly legal positions outside noise mode, the rest anywhere from 0 to DEPTH
            if (mode != MODE_NOISE && $urandom_range(0, 9) < 7) begin
                if (cmd == CMD_DELETE)
                    pos = (gen_len > 0) ? $urandom_range(0, gen_len - 1) : 0;
                else
                    pos = $urandom_range(0, gen_len);
            end else begin
                pos = $urandom_range(0, DEPTH);
            end
            if (cmd == CMD_FIND && word_pool.size() > 0 && $urandom_range(0, 9) < 7)
                val = word_pool[$urandom_range(0, word_pool.size() - 1)];
            else
                val = pick_word();
            drain = (n == 0) || ($urandom_range(0, 49) == 0);
            queue_list_req(cmd, pos, val, drain);
        end
    endtask

    // Driver: presents queued requests in bursts separated by idle gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start    <= 1'b0;
            i_command  <= '0;
            i_position <= '0;
            i_value    <= '0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (i_start && !o_busy) begin
                predict_list_op(list_reqs_q.pop_front());
                if (burst_left > 0)
                    burst_left = burst_left - 1;
                if (burst_left == 0) begin
                    gap_left   = $urandom_range(1, 24);
                    burst_left = $urandom_range(1, 40);
                end
            end
            // A request waiting on a busy engine is held as it is
            if (!(i_start && o_busy)) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    i_start <= 1'b0;
                end else if (list_reqs_q.size() > 0 &&
                             (!list_reqs_q[0].drain || list_results_q.size() == 0)) begin
                    i_start    <= 1'b1;
                    i_command  <= list_reqs_q[0].cmd;
                    i_position <= list_reqs_q[0].pos;
                    i_value    <= list_reqs_q[0].val;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (list_results_q.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result status=%0d found=%0d count=%0d",
                         $time, o_status, o_found, o_count,
                         " data=%h last=%0d", o_data, o_last);
            end else begin
                t_list_result e;
                e = list_results_q.pop_front();
                if (o_status !== e.status || o_found !== e.found || o_count !== e.count ||
                    o_data !== e.data || o_last !== e.last) begin
                    fail_count++;
                    $display("%0t: mismatch expected status=%0d found=%0d count=%0d",
                             $time, e.status, e.found, e.count,
                             " data=%h last=%0d,", e.data, e.last,
                             " actual status=%0d found=%0d count=%0d",
                             o_status, o_found, o_count,
                             " data=%h last=%0d", o_data, o_last);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        fail_count = 0;
        shadow_len = 0;
        gen_len    = 0;
        for (int k = 0; k < DEPTH; k++)
            shadow_words[k] = '0;

        // Empty list corner cases and unused command codes
        queue_list_req(CMD_POP,     0, '0, 1'b0);
        queue_list_req(CMD_DELETE,  0, '0, 1'b0);
        queue_list_req(CMD_FIND,    0, '0, 1'b0);
        queue_list_req(CMD_DUMP,    0, '0, 1'b0);
        queue_list_req(CMD_SPARE_A, 3, 32'h5a5a_a5a5, 1'b0);
        queue_list_req(CMD_SPARE_B, DEPTH, '1, 1'b0);
        queue_list_req(CMD_INSERT,  1, 32'h1111_2222, 1'b0);
        // Insert at zero, append, insert at the count
        queue_list_req(CMD_INSERT,  0, '1, 1'b0);
        queue_list_req(CMD_APPEND,  0, '0, 1'b0);
        queue_list_req(CMD_INSERT,  2, 32'h8000_0001, 1'b0);
        queue_list_req(CMD_FIND,    0, '1, 1'b0);
        queue_list_req(CMD_FIND,    0, 32'h0000_0001, 1'b0);
        queue_list_req(CMD_DELETE,  3, '0, 1'b0);
        queue_list_req(CMD_DELETE,  DEPTH, '0, 1'b0);
        queue_list_req(CMD_DELETE,  0, '0, 1'b0);
        queue_list_req(CMD_DUMP,    0, '0, 1'b0);
        queue_list_req(CMD_DELETE,  1, '0, 1'b0);
        queue_list_req(CMD_INSERT,  DEPTH, '0, 1'b0);
        queue_list_req(CMD_POP,     0, '0, 1'b0);
        queue_list_req(CMD_DUMP,    0, '0, 1'b0);

        build_random_reqs();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do
            @(negedge i_clk);
        while (list_reqs_q.size() != 0 || list_results_q.size() != 0);
        repeat (TAIL_WAIT) @(negedge i_clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog
    initial begin
        #400us;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/olist_pkg.sv
design/olist_ram.sv
design/olist_ctrl.sv
design/olist_dp.sv
design/ordered_list_engine.sv
test/tb_top.sv
